// ----- design/indexed_min_heap_decrease_key_defines.svh -----
// Assertion macros used by the indexed min-heap top level.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_DEFINES_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_DEFINES_SVH

// Same-cycle implication checked on every rising edge outside reset.
`define IMHDK_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define IMHDK_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/imhdk_pkg.sv -----
// Package with the constants, codes and compare function of the indexed min-heap.
package imhdk_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int PW             = 10;
  localparam int KW             = 32;
  localparam int OPW            = 2;
  localparam int STW            = 2;
  localparam int OCW            = 11;
  localparam int IN_DW          = 48;
  localparam int OUT_DW         = 24;

  localparam logic [OPW-1:0] OP_INSERT   = 2'd0;
  localparam logic [OPW-1:0] OP_DECREASE = 2'd1;
  localparam logic [OPW-1:0] OP_EXTRACT  = 2'd2;

  localparam logic [STW-1:0] ST_OK         = 2'd0;
  localparam logic [STW-1:0] ST_EMPTY      = 2'd1;
  localparam logic [STW-1:0] ST_FULL_QUEUE = 2'd2;
  localparam logic [STW-1:0] ST_ABSENT_LOW = 2'd3;

  // Heap order: smaller key first, smaller point number on equal keys.
  function automatic logic precedes(input logic [PW-1:0] pa, input logic [KW-1:0] ka,
                                    input logic [PW-1:0] pb, input logic [KW-1:0] kb);
    precedes = (ka < kb) || ((ka == kb) && (pa < pb));
  endfunction

endpackage

// ----- design/imhdk_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module imhdk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/indexed_min_heap_decrease_key.sv -----
// Top level of the indexed binary min-heap with decrease-key.
// After reset the block sweeps the position memory, one entry per cycle, and accepts
// no transfer until that pass ends. Each operation then runs on one sequencer over
// three RAMs (heap slots, position of each point, key of each point) with one shared
// key compare. Insert and decrease-key climb the heap one level at a time towards the
// root; extract-min moves the last point to the root and descends one level at a time.
// Each dependent lookup waits for the registered read data of the memory before it.
// One result transfer follows every input transfer, and a new input is taken while a
// result still waits.
`include "indexed_min_heap_decrease_key_defines.svh"

module indexed_min_heap_decrease_key
  import imhdk_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // point [9:0], key [41:10], zero fill
  input  logic [OPW-1:0]    in_tuser,   // op [1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // min_point [9:0], count [20:10], zero fill
  output logic [STW-1:0]    out_tuser   // status [1:0]
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int LW = AW + 2;

  typedef enum logic [14:0] {
    S_CLEAR   = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_LOOK    = 15'b000000000000100,
    S_DECIDE  = 15'b000000000001000,
    S_UPRD    = 15'b000000000010000,
    S_UPKEY   = 15'b000000000100000,
    S_UPCMP   = 15'b000000001000000,
    S_PLACE   = 15'b000000010000000,
    S_LASTRD  = 15'b000000100000000,
    S_LASTKEY = 15'b000001000000000,
    S_LASTGET = 15'b000010000000000,
    S_DNL     = 15'b000100000000000,
    S_DNLK    = 15'b001000000000000,
    S_DNR     = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [OPW-1:0]  op_r, op_nxt;
  logic [PW-1:0]   pt_r, pt_nxt;
  logic [KW-1:0]   key_r, key_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   s_r, s_nxt;
  logic [PW-1:0]   mov_p_r, mov_p_nxt;
  logic [KW-1:0]   mov_k_r, mov_k_nxt;
  logic [PW-1:0]   cand_p_r, cand_p_nxt;
  logic [PW-1:0]   best_p_r, best_p_nxt;
  logic [KW-1:0]   best_k_r, best_k_nxt;
  logic            best_ch_r, best_ch_nxt;
  logic [AW-1:0]   best_s_r, best_s_nxt;
  logic            rchk_r, rchk_nxt;
  logic [PW-1:0]   minp_r, minp_nxt;
  logic [STW-1:0]  st_r, st_nxt;
  logic            ovld_r, ovld_nxt;
  logic [PW-1:0]   omin_r, omin_nxt;
  logic [STW-1:0]  ost_r, ost_nxt;
  logic [CW-1:0]   ocnt_r, ocnt_nxt;

  logic            hp_we, sl_we, ky_we;
  logic [AW-1:0]   hp_wa, sl_wa, ky_wa, hp_ra, sl_ra, ky_ra;
  logic [PW-1:0]   hp_wd, hp_rd;
  logic [AW:0]     sl_wd, sl_rd;
  logic [KW-1:0]   ky_wd, ky_rd;

  logic [PW-1:0]   cmp_ap, cmp_bp;
  logic [KW-1:0]   cmp_ak, cmp_bk;
  logic            cmp_lt;
  logic [LW-1:0]   l_w, r_w, cnt_w;
  logic            pt_bad;

  imhdk_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_heap (
    .clk(clk), .we(hp_we), .waddr(hp_wa), .wdata(hp_wd), .raddr(hp_ra), .rdata(hp_rd)
  );
  imhdk_ram #(.WIDTH(AW + 1), .DEPTH(MAX_POINTS)) u_slot (
    .clk(clk), .we(sl_we), .waddr(sl_wa), .wdata(sl_wd), .raddr(sl_ra), .rdata(sl_rd)
  );
  imhdk_ram #(.WIDTH(KW), .DEPTH(MAX_POINTS)) u_key (
    .clk(clk), .we(ky_we), .waddr(ky_wa), .wdata(ky_wd), .raddr(ky_ra), .rdata(ky_rd)
  );

  assign l_w    = LW'({s_r, 1'b1});
  assign r_w    = l_w + LW'(1);
  assign cnt_w  = LW'(cnt_r);
  assign pt_bad = (32'(pt_r) >= 32'(MAX_POINTS));

  always_comb begin
    if (state_r == S_UPCMP) begin
      cmp_ap = mov_p_r;
      cmp_ak = mov_k_r;
      cmp_bp = cand_p_r;
      cmp_bk = ky_rd;
    end else begin
      cmp_ap = cand_p_r;
      cmp_ak = ky_rd;
      cmp_bp = best_p_r;
      cmp_bk = best_k_r;
    end
    cmp_lt = precedes(cmp_ap, cmp_ak, cmp_bp, cmp_bk);
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = OUT_DW'({OCW'(ocnt_r), omin_r});
  assign out_tuser  = ost_r;

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    op_nxt      = op_r;
    pt_nxt      = pt_r;
    key_nxt     = key_r;
    cnt_nxt     = cnt_r;
    s_nxt       = s_r;
    mov_p_nxt   = mov_p_r;
    mov_k_nxt   = mov_k_r;
    cand_p_nxt  = cand_p_r;
    best_p_nxt  = best_p_r;
    best_k_nxt  = best_k_r;
    best_ch_nxt = best_ch_r;
    best_s_nxt  = best_s_r;
    rchk_nxt    = rchk_r;
    minp_nxt    = minp_r;
    st_nxt      = st_r;
    ovld_nxt    = ovld_r;
    omin_nxt    = omin_r;
    ost_nxt     = ost_r;
    ocnt_nxt    = ocnt_r;
    hp_we = 1'b0;
    hp_wa = s_r;
    hp_wd = mov_p_r;
    hp_ra = '0;
    sl_we = 1'b0;
    sl_wa = AW'(mov_p_r);
    sl_wd = {1'b1, s_r};
    sl_ra = AW'(pt_r);
    ky_we = 1'b0;
    ky_wa = AW'(pt_r);
    ky_wd = key_r;
    ky_ra = AW'(pt_r);

    if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        sl_we = 1'b1;
        sl_wa = clr_r;
        sl_wd = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_POINTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          pt_nxt    = in_tdata[PW-1:0];
          key_nxt   = in_tdata[PW+KW-1:PW];
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        minp_nxt  = '0;
        st_nxt    = ST_OK;
        state_nxt = S_DONE;
        case (op_r)
          OP_INSERT: begin
            if (pt_bad) begin
              st_nxt = ST_ABSENT_LOW;
            end else if ((cnt_r >= CW'(MAX_POINTS)) || sl_rd[AW]) begin
              st_nxt = ST_FULL_QUEUE;
            end else begin
              ky_we     = 1'b1;
              mov_p_nxt = pt_r;
              mov_k_nxt = key_r;
              s_nxt     = AW'(cnt_r);
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = S_UPRD;
            end
          end
          OP_DECREASE: begin
            if (pt_bad || !sl_rd[AW] || (key_r >= ky_rd)) begin
              st_nxt = ST_ABSENT_LOW;
            end else begin
              ky_we     = 1'b1;
              mov_p_nxt = pt_r;
              mov_k_nxt = key_r;
              s_nxt     = sl_rd[AW-1:0];
              state_nxt = S_UPRD;
            end
          end
          OP_EXTRACT: begin
            if (cnt_r == '0) begin
              st_nxt = ST_EMPTY;
            end else begin
              minp_nxt = hp_rd;
              sl_we    = 1'b1;
              sl_wa    = AW'(hp_rd);
              sl_wd    = '0;
              cnt_nxt  = cnt_r - CW'(1);
              s_nxt    = '0;
              if (cnt_r != CW'(1)) begin
                state_nxt = S_LASTRD;
              end
            end
          end
          default: begin
            st_nxt = ST_OK;
          end
        endcase
      end
      S_UPRD: begin
        hp_ra = (s_r - AW'(1)) >> 1;
        if (s_r == '0) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_UPKEY;
        end
      end
      S_UPKEY: begin
        cand_p_nxt = hp_rd;
        ky_ra      = AW'(hp_rd);
        state_nxt  = S_UPCMP;
      end
      S_UPCMP: begin
        if (cmp_lt) begin
          hp_we     = 1'b1;
          hp_wd     = cand_p_r;
          sl_we     = 1'b1;
          sl_wa     = AW'(cand_p_r);
          s_nxt     = (s_r - AW'(1)) >> 1;
          state_nxt = S_UPRD;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        hp_we     = 1'b1;
        sl_we     = 1'b1;
        state_nxt = S_DONE;
      end
      S_LASTRD: begin
        hp_ra     = AW'(cnt_r);
        state_nxt = S_LASTKEY;
      end
      S_LASTKEY: begin
        mov_p_nxt = hp_rd;
        ky_ra     = AW'(hp_rd);
        state_nxt = S_LASTGET;
      end
      S_LASTGET: begin
        mov_k_nxt = ky_rd;
        state_nxt = S_DNL;
      end
      S_DNL: begin
        hp_ra       = AW'(l_w);
        best_p_nxt  = mov_p_r;
        best_k_nxt  = mov_k_r;
        best_ch_nxt = 1'b0;
        rchk_nxt    = 1'b0;
        if (l_w >= cnt_w) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_DNLK;
        end
      end
      S_DNLK: begin
        cand_p_nxt = hp_rd;
        ky_ra      = AW'(hp_rd);
        hp_ra      = AW'(r_w);
        state_nxt  = S_DNR;
      end
      S_DNR: begin
        // Up to two passes: left child against the moving point, then any right child vs best.
        if (cmp_lt) begin
          best_p_nxt  = cand_p_r;
          best_k_nxt  = ky_rd;
          best_ch_nxt = 1'b1;
          best_s_nxt  = rchk_r ? AW'(r_w) : AW'(l_w);
        end
        if (!rchk_r && (r_w < cnt_w)) begin
          rchk_nxt   = 1'b1;
          cand_p_nxt = hp_rd;
          ky_ra      = AW'(hp_rd);
        end else if (cmp_lt || best_ch_r) begin
          hp_we     = 1'b1;
          hp_wd     = cmp_lt ? cand_p_r : best_p_r;
          sl_we     = 1'b1;
          sl_wa     = cmp_lt ? AW'(cand_p_r) : AW'(best_p_r);
          s_nxt     = cmp_lt ? (rchk_r ? AW'(r_w) : AW'(l_w)) : best_s_r;
          state_nxt = S_DNL;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_DONE: begin
        if (!ovld_r || out_tready) begin
          ovld_nxt  = 1'b1;
          omin_nxt  = minp_r;
          ost_nxt   = st_r;
          ocnt_nxt  = cnt_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    pt_r      <= pt_nxt;
    key_r     <= key_nxt;
    s_r       <= s_nxt;
    mov_p_r   <= mov_p_nxt;
    mov_k_r   <= mov_k_nxt;
    cand_p_r  <= cand_p_nxt;
    best_p_r  <= best_p_nxt;
    best_k_r  <= best_k_nxt;
    best_ch_r <= best_ch_nxt;
    best_s_r  <= best_s_nxt;
    rchk_r    <= rchk_nxt;
    minp_r    <= minp_nxt;
    st_r      <= st_nxt;
    omin_r    <= omin_nxt;
    ost_r     <= ost_nxt;
    ocnt_r    <= ocnt_nxt;
  end

  `IMHDK_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_POINTS), "heap count beyond capacity")
  `IMHDK_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready, "ready right after a transfer")
  `IMHDK_ASSERT_IMPL(a_rise_not_root, state_r == S_UPCMP, s_r != '0, "parent compare at the root")
  `IMHDK_ASSERT_IMPL(a_empty_count, ovld_r && (ost_r == ST_EMPTY), ocnt_r == '0, "empty status with points queued")

endmodule

// ----- verif/indexed_min_heap_decrease_key_chk.sv -----
// Checker that predicts and compares every result of the indexed min-heap.
module indexed_min_heap_decrease_key_chk
  import imhdk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic [OPW-1:0]    in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,
  input  logic [STW-1:0]    out_tuser,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PW-1:0]  min_point;
    logic [STW-1:0] status;
    logic [OCW-1:0] count;
  } heap_result_t;

  logic [PW-1:0]  slot_point [MAX_POINTS_DEF];
  logic [OCW-1:0] point_slot [MAX_POINTS_DEF];
  logic           point_live [MAX_POINTS_DEF];
  logic [KW-1:0]  point_key  [MAX_POINTS_DEF];
  logic [OCW-1:0] queued_cnt;
  heap_result_t   awaited_results[$];

  assign pending = awaited_results.size();

  function automatic logic ahead(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (point_key[a] < point_key[b]) || (point_key[a] == point_key[b] && a < b);
  endfunction

  function automatic void swap_slots(input int s, input int t);
    logic [PW-1:0] ps;
    logic [PW-1:0] pt;
    ps = slot_point[PW'(s)];
    pt = slot_point[PW'(t)];
    slot_point[PW'(s)] = pt;
    slot_point[PW'(t)] = ps;
    point_slot[ps] = OCW'(t);
    point_slot[pt] = OCW'(s);
  endfunction

  function automatic void sift_up(input int s);
    int up;
    while (s > 0 && s < queued_cnt) begin
      up = (s - 1) / 2;
      if (!ahead(slot_point[PW'(s)], slot_point[PW'(up)])) break;
      swap_slots(s, up);
      s = up;
    end
  endfunction

  function automatic void sift_down(input int s);
    int best;
    forever begin
      best = s;
      if (2*s+1 < queued_cnt && ahead(slot_point[PW'(2*s+1)], slot_point[PW'(best)]))
        best = 2*s+1;
      if (2*s+2 < queued_cnt && ahead(slot_point[PW'(2*s+2)], slot_point[PW'(best)]))
        best = 2*s+2;
      if (best == s) break;
      swap_slots(s, best);
      s = best;
    end
  endfunction

  function automatic heap_result_t apply_op(input logic [OPW-1:0] op,
                                            input logic [PW-1:0] pt,
                                            input logic [KW-1:0] key);
    heap_result_t r;
    logic [PW-1:0] last;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (queued_cnt >= MAX_POINTS_DEF || point_live[pt]) begin
          r.status = ST_FULL_QUEUE;
        end else begin
          point_key[pt] = key;
          slot_point[queued_cnt[PW-1:0]] = pt;
          point_slot[pt] = queued_cnt;
          point_live[pt] = 1'b1;
          queued_cnt = queued_cnt + OCW'(1);
          sift_up(int'(queued_cnt) - 1);
        end
      end
      OP_DECREASE: begin
        if (!point_live[pt] || key >= point_key[pt]) begin
          r.status = ST_ABSENT_LOW;
        end else begin
          point_key[pt] = key;
          sift_up(int'(point_slot[pt]));
        end
      end
      OP_EXTRACT: begin
        if (queued_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.min_point = slot_point[0];
          queued_cnt = queued_cnt - OCW'(1);
          if (queued_cnt > 0) begin
            last = slot_point[queued_cnt[PW-1:0]];
            slot_point[0] = last;
            point_slot[last] = '0;
            sift_down(0);
          end
          point_live[r.min_point] = 1'b0;
        end
      end
      default: ;
    endcase
    r.count = queued_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    heap_result_t want;
    if (!rst_n) begin
      errors = 0;
      queued_cnt = '0;
      foreach (point_live[i]) point_live[i] = 1'b0;
      awaited_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        awaited_results.push_back(apply_op(in_tuser, in_tdata[PW-1:0], in_tdata[PW+KW-1:PW]));
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result transfer", 1, 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata[PW-1:0] !== want.min_point)
            report_mismatch("min_point", int'(out_tdata[PW-1:0]), int'(want.min_point));
          if (out_tuser !== want.status)
            report_mismatch("status", int'(out_tuser), int'(want.status));
          if (out_tdata[PW+OCW-1:PW] !== want.count)
            report_mismatch("count", int'(out_tdata[PW+OCW-1:PW]), int'(want.count));
        end
      end
    end
  end

endmodule

// ----- verif/indexed_min_heap_decrease_key_tb.sv -----
// Testbench top that drives the indexed min-heap and gives the verdict.
module indexed_min_heap_decrease_key_tb
  import imhdk_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OPW-1:0] OP_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_LEN = 400;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;
  logic [OPW-1:0]    in_tuser;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic [STW-1:0]    out_tuser;
  int                errors;
  int                pending;
  int                send_idle_pct;
  int                recv_idle_pct;
  logic              hold_req;
  logic              hold_taken = 1'b0;
  int                hold_left = 0;
  int                cycles = 0;

  indexed_min_heap_decrease_key dut (.*);

  indexed_min_heap_decrease_key_chk chk (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("indexed_min_heap_decrease_key test failed");
      $finish;
    end
  end

  // The receiver stalls at random, or for a long stretch when asked to.
  always begin
    @(negedge clk);
    if (hold_req && !hold_taken) begin
      hold_left = HOLD_LEN;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      @(posedge clk);
      out_tready <= 1'b0;
    end else begin
      @(posedge clk);
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_op(input logic [OPW-1:0] op, input logic [PW-1:0] pt,
                         input logic [KW-1:0] key);
    logic rdy;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DW-KW-PW){1'b0}}, key, pt};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic random_ops(input int n);
    int roll;
    logic [PW-1:0] pt;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      pt = ($urandom_range(0, 9) < 8) ? PW'($urandom_range(0, 31)) : PW'($urandom);
      if (roll < 45)      send_op(OP_INSERT, pt, $urandom);
      else if (roll < 72) send_op(OP_DECREASE, pt, $urandom >> $urandom_range(0, 12));
      else if (roll < 96) send_op(OP_EXTRACT, PW'($urandom), $urandom);
      else                send_op(OP_NONE, PW'($urandom), $urandom);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_NONE;
    hold_req = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 82;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_op(OP_EXTRACT, '0, '0);
    send_op(OP_INSERT, 10'd0, 32'h0000_0000);
    send_op(OP_INSERT, 10'd1023, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 10'd5, 32'h0000_0000);
    send_op(OP_INSERT, 10'd0, 32'h1234_5678);
    send_op(OP_DECREASE, 10'd1023, 32'h0000_0000);
    send_op(OP_DECREASE, 10'd1023, 32'h0000_0000);
    send_op(OP_DECREASE, 10'd7, 32'h0000_0001);
    send_op(OP_NONE, 10'h3FF, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 10'd512, 32'hAAAA_5555);
    send_op(OP_INSERT, 10'd341, 32'h5555_AAAA);
    send_op(OP_DECREASE, 10'd512, 32'h0000_0001);
    send_op(OP_DECREASE, 10'd341, 32'h5555_AAAA);
    repeat (6) send_op(OP_EXTRACT, '0, '0);
    send_op(OP_DECREASE, 10'd0, 32'h0000_0000);
    random_ops(150);
    wait_idle();

    send_idle_pct = 82;
    recv_idle_pct = 22;
    random_ops(150);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    for (int p = 0; p < MAX_POINTS_DEF; p++) send_op(OP_INSERT, PW'(p), $urandom);
    send_op(OP_INSERT, 10'd77, 32'h0000_0000);
    for (int i = 0; i < 20; i++)
      send_op(OP_DECREASE, PW'($urandom), $urandom >> $urandom_range(0, 20));
    random_ops(40);
    wait_idle();

    if (errors == 0) $display("indexed_min_heap_decrease_key test passed");
    else $display("indexed_min_heap_decrease_key test failed");
    $finish;
  end

endmodule
